// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and codes for the round-robin task table scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  // request codes
  localparam logic [2:0] REQ_CREATE    = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE  = 3'd1;
  localparam logic [2:0] REQ_SLEEP     = 3'd2;
  localparam logic [2:0] REQ_KILL      = 3'd3;
  localparam logic [2:0] REQ_TERMINATE = 3'd4;
  localparam logic [2:0] REQ_CLEANUP   = 3'd5;

  // status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_PROTECTED = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_BAD_PRIV  = 3'd4;
  localparam logic [2:0] STAT_NO_TASKS  = 3'd5;

  // task states
  localparam logic [1:0] TS_READY    = 2'd0;
  localparam logic [1:0] TS_RUNNING  = 2'd1;
  localparam logic [1:0] TS_SLEEPING = 2'd2;
  localparam logic [1:0] TS_ZOMBIE   = 2'd3;

  // highest id that kill and cleanup protect, and highest id terminate refuses
  localparam logic [31:0] KILL_MIN_ID = 32'd3;
  localparam logic [31:0] TERM_MIN_ID = 32'd1;

  // reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> 35
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [4:0] RM_MAX = 5'd31;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] id;
    logic [47:0] wake;
    logic [63:0] ctx;
    logic [51:0] page;
  } slot_ent_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_RMW_RD,
    FSM_RMW_WR,
    FSM_DONE
  } fsm_t;

endpackage

`default_nettype wire

// ===== rtl/rrts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// rrts_slot_mem
// task slot memory, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_slot_mem #(
  parameter int NUM_TASKS = 16
) (
  input  wire                                  clk,
  input  wire  [$clog2(NUM_TASKS)-1:0]         raddr,
  output rrts_pkg::slot_ent_t                  rdata,
  input  wire                                  wen,
  input  wire  [$clog2(NUM_TASKS)-1:0]         waddr,
  input  rrts_pkg::slot_ent_t                  wdata
);

  rrts_pkg::slot_ent_t mem [NUM_TASKS];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/round_robin_task_table_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_table_scheduler_top
// task table of NUM_TASKS slots serving create, schedule, sleep, kill,
// terminate and cleanup requests
// ----------------------------------------------------------------------------
// usage
//   input channel in_* carries one request (valid/ready), output channel
//   out_* returns exactly one result per request, in order
//   slot payload (state, id, wake tick, context, page base) lives in one
//   synchronous memory; valid bits and the current-task pointer are flops
//   create, schedule, kill and cleanup sweep all slots, one slot a cycle
//   through the memory read port; schedule, and a kill that finds its
//   task, then add a read-modify-write of the chosen slot
//   sleep with a nonzero time and terminate do one read-modify-write of
//   the current slot; requests refused at acceptance skip sweep and update
//   and go straight to the final state
//   the next request is taken in the cycle after a result is loaded
//   one request at a time; a finished result sits in the output register
//   so the next request is taken while the receiver stalls, and that
//   request then waits in its final state until the output register frees
//   reset clears the valid bits, the current task and sets the id counter
//   to one; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_table_scheduler_top #(
  parameter int NUM_TASKS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_req_type,
  input  wire  [31:0] in_task_id,
  input  wire  [47:0] in_now_tick,
  input  wire  [31:0] in_sleep_ms,
  input  wire  [63:0] in_saved_context,
  input  wire  [63:0] in_page_base,
  input  wire  [1:0]  in_privilege,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_id,
  output logic [63:0] out_context_out,
  output logic [63:0] out_page_base_out,
  output logic        out_reschedule,
  output logic [4:0]  out_removed_count
);

  localparam int IW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int RECIP_LO = rrts_pkg::RECIP10_SHIFT;

  rrts_pkg::fsm_t state_r, state_nxt;

  // latched request
  logic [2:0]  req_r;
  logic [31:0] kid_r;
  logic [47:0] now_r;
  logic [31:0] ms_r;
  logic [63:0] ctx_r;
  logic [63:0] pb_r;
  logic [1:0]  priv_r;

  // table control
  logic [NUM_TASKS-1:0] valid_r;
  logic [IW-1:0]        cur_slot_r;
  logic                 cur_valid_r;
  logic [31:0]          cur_id_r;
  logic [31:0]          next_id_r;

  // sweep counter and trackers
  logic [CW-1:0] cnt_r;
  logic          head_vld_r, best_vld_r, below_vld_r, free_vld_r, km_vld_r;
  logic [IW-1:0] head_idx_r, best_idx_r, below_idx_r, free_idx_r, km_idx_r;
  logic [31:0]   head_id_r, best_id_r, below_id_r;
  logic [63:0]   prod_r;

  // pending result
  logic [2:0]  res_status_r;
  logic [31:0] res_rid_r;
  logic [63:0] res_ctx_r;
  logic [63:0] res_pb_r;
  logic        res_resch_r;
  logic [4:0]  res_rm_r;

  // memory ports
  logic [IW-1:0]       mem_raddr, mem_waddr;
  logic                mem_wen;
  rrts_pkg::slot_ent_t mem_rdata, mem_wdata;

  rrts_slot_mem #(.NUM_TASKS(NUM_TASKS)) u_mem (
    .clk   (clk),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // ---------------------------------------------------------------- decode
  logic          acc;
  logic          cur_w;
  logic          any_valid;
  logic          sweep_end, proc;
  logic [IW-1:0] p;
  logic          pv, is_cur, cur_gt;
  logic [1:0]    st_eff;
  logic          free_any, kill_any, priv_ok;
  logic [IW-1:0] free_sel, choice, rmw_addr;
  logic [28:0]   quo;
  logic [47:0]   wait_t;

  assign acc       = in_valid && in_ready;
  assign cur_w     = cur_valid_r && valid_r[cur_slot_r];
  assign any_valid = |valid_r;
  assign sweep_end = (cnt_r == CW'(NUM_TASKS));
  // entry p arrives from memory in the cycle after its read was issued
  assign proc      = (state_r == rrts_pkg::FSM_SCAN) && (cnt_r != '0);
  assign p         = IW'(cnt_r - CW'(1));
  assign pv        = valid_r[p];
  assign is_cur    = cur_w && (p == cur_slot_r);
  // current task ranks above entry p in (id, slot) order
  assign cur_gt    = (cur_id_r > mem_rdata.id) ||
                     ((cur_id_r == mem_rdata.id) && (cur_slot_r > p));
  assign priv_ok   = (priv_r == 2'd0) || (priv_r == 2'd3);

  // state of the swept entry after waking and demoting the current task
  always_comb begin
    st_eff = mem_rdata.st;
    if ((st_eff == rrts_pkg::TS_SLEEPING) && (now_r >= mem_rdata.wake)) begin
      st_eff = rrts_pkg::TS_READY;
    end
    if (is_cur && (st_eff == rrts_pkg::TS_RUNNING)) begin
      st_eff = rrts_pkg::TS_READY;
    end
  end

  // lowest free slot and last id match, including the entry in flight
  assign free_any = free_vld_r || (proc && !pv);
  assign free_sel = free_vld_r ? free_idx_r : p;
  assign kill_any = km_vld_r || (proc && pv && (mem_rdata.id == kid_r));

  assign choice = below_vld_r ? below_idx_r :
                  best_vld_r  ? best_idx_r  : head_idx_r;

  always_comb begin
    case (req_r)
      rrts_pkg::REQ_SCHEDULE: rmw_addr = choice;
      rrts_pkg::REQ_KILL:     rmw_addr = km_idx_r;
      default:                rmw_addr = cur_slot_r;
    endcase
  end

  // sleep wait: ms / 10 through the reciprocal, at least one tick
  assign quo    = prod_r[63:RECIP_LO];
  assign wait_t = (quo == '0) ? 48'd1 : 48'(quo);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::FSM_IDLE: begin
        if (acc) begin
          case (in_req_type)
            rrts_pkg::REQ_CREATE, rrts_pkg::REQ_CLEANUP: state_nxt = rrts_pkg::FSM_SCAN;
            rrts_pkg::REQ_SCHEDULE:
              state_nxt = any_valid ? rrts_pkg::FSM_SCAN : rrts_pkg::FSM_DONE;
            rrts_pkg::REQ_KILL:
              state_nxt = (in_task_id > rrts_pkg::KILL_MIN_ID) ? rrts_pkg::FSM_SCAN
                                                               : rrts_pkg::FSM_DONE;
            rrts_pkg::REQ_SLEEP:
              state_nxt = ((in_sleep_ms != '0) && cur_w) ? rrts_pkg::FSM_RMW_RD
                                                         : rrts_pkg::FSM_DONE;
            rrts_pkg::REQ_TERMINATE:
              state_nxt = (cur_w && (cur_id_r > rrts_pkg::TERM_MIN_ID))
                          ? rrts_pkg::FSM_RMW_RD : rrts_pkg::FSM_DONE;
            default: state_nxt = rrts_pkg::FSM_DONE;
          endcase
        end
      end
      rrts_pkg::FSM_SCAN: begin
        if (sweep_end) begin
          case (req_r)
            rrts_pkg::REQ_SCHEDULE: state_nxt = rrts_pkg::FSM_RMW_RD;
            rrts_pkg::REQ_KILL:
              state_nxt = kill_any ? rrts_pkg::FSM_RMW_RD : rrts_pkg::FSM_DONE;
            default: state_nxt = rrts_pkg::FSM_DONE;
          endcase
        end
      end
      rrts_pkg::FSM_RMW_RD: state_nxt = rrts_pkg::FSM_RMW_WR;
      rrts_pkg::FSM_RMW_WR: state_nxt = rrts_pkg::FSM_DONE;
      rrts_pkg::FSM_DONE: begin
        if (!out_valid || out_ready) begin
          state_nxt = rrts_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = rrts_pkg::FSM_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    in_ready  = (state_r == rrts_pkg::FSM_IDLE);
    mem_raddr = (state_r == rrts_pkg::FSM_SCAN) ? cnt_r[IW-1:0] : rmw_addr;
    mem_wen   = 1'b0;
    mem_waddr = p;
    mem_wdata = mem_rdata;
    case (state_r)
      rrts_pkg::FSM_SCAN: begin
        if ((req_r == rrts_pkg::REQ_SCHEDULE) && proc && pv) begin
          // write back woken / demoted state and the outgoing context
          mem_wen      = 1'b1;
          mem_wdata.st = st_eff;
          if (is_cur) begin
            mem_wdata.ctx = ctx_r;
          end
        end else if ((req_r == rrts_pkg::REQ_CREATE) && sweep_end && free_any && priv_ok) begin
          mem_wen        = 1'b1;
          mem_waddr      = free_sel;
          mem_wdata.st   = rrts_pkg::TS_READY;
          mem_wdata.id   = next_id_r;
          mem_wdata.wake = '0;
          mem_wdata.ctx  = ctx_r;
          mem_wdata.page = pb_r[63:12];
        end
      end
      rrts_pkg::FSM_RMW_WR: begin
        mem_waddr = rmw_addr;
        case (req_r)
          rrts_pkg::REQ_SCHEDULE: begin
            mem_wen      = 1'b1;
            mem_wdata.st = rrts_pkg::TS_RUNNING;
          end
          rrts_pkg::REQ_SLEEP: begin
            mem_wen        = 1'b1;
            mem_wdata.st   = rrts_pkg::TS_SLEEPING;
            mem_wdata.wake = now_r + wait_t;
          end
          rrts_pkg::REQ_KILL, rrts_pkg::REQ_TERMINATE: begin
            mem_wen      = (mem_rdata.st != rrts_pkg::TS_ZOMBIE);
            mem_wdata.st = rrts_pkg::TS_ZOMBIE;
          end
          default: mem_wen = 1'b0;
        endcase
      end
      default: mem_wen = 1'b0;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      next_id_r   <= 32'd1;
      out_valid   <= 1'b0;
    end else begin
      case (state_r)
        rrts_pkg::FSM_IDLE: begin
          if (acc) begin
            req_r        <= in_req_type;
            kid_r        <= in_task_id;
            now_r        <= in_now_tick;
            ms_r         <= in_sleep_ms;
            ctx_r        <= in_saved_context;
            pb_r         <= in_page_base;
            priv_r       <= in_privilege;
            cnt_r        <= '0;
            head_vld_r   <= 1'b0;
            best_vld_r   <= 1'b0;
            below_vld_r  <= 1'b0;
            free_vld_r   <= 1'b0;
            km_vld_r     <= 1'b0;
            res_rid_r    <= '0;
            res_pb_r     <= '0;
            res_resch_r  <= 1'b0;
            res_rm_r     <= '0;
            // empty-table schedule hands the incoming context straight back
            res_ctx_r    <= ((in_req_type == rrts_pkg::REQ_SCHEDULE) && !any_valid)
                            ? in_saved_context : '0;
            // requests refused up front
            case (in_req_type)
              rrts_pkg::REQ_SCHEDULE: begin
                res_status_r <= any_valid ? rrts_pkg::STAT_OK : rrts_pkg::STAT_NO_TASKS;
              end
              rrts_pkg::REQ_SLEEP: begin
                res_status_r <= ((in_sleep_ms != '0) && !cur_w) ? rrts_pkg::STAT_NO_TASKS
                                                                : rrts_pkg::STAT_OK;
              end
              rrts_pkg::REQ_KILL: begin
                res_status_r <= (in_task_id <= rrts_pkg::KILL_MIN_ID)
                                ? rrts_pkg::STAT_PROTECTED : rrts_pkg::STAT_OK;
              end
              rrts_pkg::REQ_TERMINATE: begin
                if (!cur_w) begin
                  res_status_r <= rrts_pkg::STAT_NO_TASKS;
                end else if (cur_id_r <= rrts_pkg::TERM_MIN_ID) begin
                  res_status_r <= rrts_pkg::STAT_PROTECTED;
                end else begin
                  res_status_r <= rrts_pkg::STAT_OK;
                end
              end
              default: res_status_r <= rrts_pkg::STAT_OK;
            endcase
          end
        end

        rrts_pkg::FSM_SCAN: begin
          if (!sweep_end) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (proc) begin
            case (req_r)
              rrts_pkg::REQ_CREATE: begin
                if (!pv && !free_vld_r) begin
                  free_vld_r <= 1'b1;
                  free_idx_r <= p;
                end
              end
              rrts_pkg::REQ_SCHEDULE: begin
                if (pv) begin
                  // ascending sweep: equal id means the later slot ranks higher
                  if (!head_vld_r || (mem_rdata.id >= head_id_r)) begin
                    head_vld_r <= 1'b1;
                    head_idx_r <= p;
                    head_id_r  <= mem_rdata.id;
                  end
                  if (st_eff == rrts_pkg::TS_READY) begin
                    if (!best_vld_r || (mem_rdata.id >= best_id_r)) begin
                      best_vld_r <= 1'b1;
                      best_idx_r <= p;
                      best_id_r  <= mem_rdata.id;
                    end
                    if (cur_w && cur_gt && (!below_vld_r || (mem_rdata.id >= below_id_r))) begin
                      below_vld_r <= 1'b1;
                      below_idx_r <= p;
                      below_id_r  <= mem_rdata.id;
                    end
                  end
                end
              end
              rrts_pkg::REQ_KILL: begin
                if (pv && (mem_rdata.id == kid_r)) begin
                  km_vld_r <= 1'b1;
                  km_idx_r <= p;
                end
              end
              rrts_pkg::REQ_CLEANUP: begin
                if (pv && (mem_rdata.st == rrts_pkg::TS_ZOMBIE) && !is_cur &&
                    (mem_rdata.id > rrts_pkg::KILL_MIN_ID)) begin
                  valid_r[p] <= 1'b0;
                  if (res_rm_r != rrts_pkg::RM_MAX) begin
                    res_rm_r <= res_rm_r + 5'd1;
                  end
                end
              end
              default: ;
            endcase
          end
          if (sweep_end) begin
            if (req_r == rrts_pkg::REQ_CREATE) begin
              if (!free_any) begin
                res_status_r <= rrts_pkg::STAT_FULL;
              end else begin
                next_id_r <= next_id_r + 32'd1;
                if (!priv_ok) begin
                  res_status_r <= rrts_pkg::STAT_BAD_PRIV;
                end else begin
                  valid_r[free_sel] <= 1'b1;
                  res_rid_r         <= next_id_r;
                  if (!cur_w) begin
                    cur_slot_r  <= free_sel;
                    cur_valid_r <= 1'b1;
                    cur_id_r    <= next_id_r;
                  end
                end
              end
            end else if ((req_r == rrts_pkg::REQ_KILL) && !kill_any) begin
              res_status_r <= rrts_pkg::STAT_NOT_FOUND;
            end
          end
        end

        rrts_pkg::FSM_RMW_RD: begin
          prod_r <= 64'(ms_r) * 64'(rrts_pkg::RECIP10);
        end

        rrts_pkg::FSM_RMW_WR: begin
          case (req_r)
            rrts_pkg::REQ_SCHEDULE: begin
              cur_slot_r  <= choice;
              cur_valid_r <= 1'b1;
              cur_id_r    <= mem_rdata.id;
              res_rid_r   <= mem_rdata.id;
              res_ctx_r   <= mem_rdata.ctx;
              res_pb_r    <= {mem_rdata.page, 12'd0};
            end
            rrts_pkg::REQ_SLEEP, rrts_pkg::REQ_TERMINATE: res_resch_r <= 1'b1;
            rrts_pkg::REQ_KILL: begin
              res_resch_r <= (mem_rdata.st != rrts_pkg::TS_ZOMBIE) && cur_w &&
                             (km_idx_r == cur_slot_r);
            end
            default: res_resch_r <= 1'b0;
          endcase
        end

        rrts_pkg::FSM_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            out_status        <= res_status_r;
            out_result_id     <= res_rid_r;
            out_context_out   <= res_ctx_r;
            out_page_base_out <= res_pb_r;
            out_reschedule    <= res_resch_r;
            out_removed_count <= res_rm_r;
          end
        end

        default: cnt_r <= cnt_r;
      endcase

      if ((state_r != rrts_pkg::FSM_DONE) && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready)
    else $error("request accepted while another in progress");

  a_cur_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |=> cur_valid_r)
    else $error("current task lost");

  a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> valid_r[cur_slot_r])
    else $error("current slot freed");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (next_id_r != $past(next_id_r))) |->
      (next_id_r == $past(next_id_r) + 32'd1))
    else $error("id counter jumped");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wen |-> ((state_r == rrts_pkg::FSM_SCAN) || (state_r == rrts_pkg::FSM_RMW_WR)))
    else $error("slot write outside sweep or update");

endmodule

`default_nettype wire
